@@ rtl/core/tfd_pkg.sv @@
package tfd_pkg;

    localparam int STAMP_W  = 64;
    localparam int HANDLE_W = 16;
    localparam int OCC_W    = 5;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_TRIM   = 2'd2,
        ACT_FLUSH  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_LOOK_BACK,
        S_SCAN_CMP,
        S_TB_CMP,
        S_TF_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        t_action                     action;
        logic signed [STAMP_W-1:0]   stamp;
        logic        [HANDLE_W-1:0]  handle_in;
        logic signed [STAMP_W-1:0]   trim_low;
        logic signed [STAMP_W-1:0]   trim_high;
    } t_req;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle_out;
        t_status             status;
        logic [OCC_W-1:0]    occupancy;
    } t_rsp;

endpackage

@@ rtl/core/tfd_ram.sv @@
module tfd_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 80
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/tfd_ctrl.sv @@
module tfd_ctrl #(
    parameter int DEPTH       = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  tfd_pkg::t_req                       i_req,
    output logic                                o_busy,
    output logic                                o_done,
    output tfd_pkg::t_rsp                       o_rsp,
    input  logic                                i_take,
    output logic                                o_wr_en,
    output logic [$clog2(DEPTH)-1:0]            o_wr_addr,
    output logic [tfd_pkg::STAMP_W+HANDLE_BITS-1:0] o_wr_data,
    output logic                                o_rd_en,
    output logic [$clog2(DEPTH)-1:0]            o_rd_addr,
    input  logic [tfd_pkg::STAMP_W+HANDLE_BITS-1:0] i_rd_data
);

    import tfd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = STAMP_W + HANDLE_BITS;

    t_state                r_state, n_state;
    logic [AW-1:0]         r_front, n_front;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_k, n_k;
    t_req                  r_req, n_req;
    logic [HANDLE_W-1:0]   r_handle, n_handle;
    t_status               r_status, n_status;

    t_req                  cur;
    logic signed [STAMP_W-1:0] rd_time;
    logic [HANDLE_W-1:0]   rd_handle;
    logic [CW-1:0]         cnt_m1;
    logic [CW-1:0]         cnt_m2;
    logic [AW-1:0]         back_slot;
    logic [AW-1:0]         front_dec;
    logic [AW-1:0]         front_inc;
    logic                  is_full;
    logic                  is_empty;
    logic                  new_is_newer;
    logic                  req_before;
    logic                  back_old;
    logic                  front_new;

    // position k from the front, wrapped into the ring
    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] k);
        logic [AW:0] sum;
        sum = (AW+1)'(base) + (AW+1)'(k);
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // shared datapath terms
    assign cur       = (r_state == S_IDLE) ? i_req : r_req;
    assign rd_time   = $signed(i_rd_data[MW-1 -: STAMP_W]);
    assign rd_handle = HANDLE_W'(i_rd_data[HANDLE_BITS-1:0]);
    assign cnt_m1    = r_count - CW'(1);
    assign cnt_m2    = r_count - CW'(2);
    assign back_slot = slot_of(r_front, cnt_m1);
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
    assign is_full   = (r_count == CW'(DEPTH));
    assign is_empty  = (r_count == '0);

    // compares against the entry read in the previous cycle
    assign new_is_newer = rd_time < r_req.stamp;
    assign req_before   = r_req.stamp < rd_time;
    assign back_old     = rd_time < r_req.trim_low;
    assign front_new    = rd_time > r_req.trim_high;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_req.action)
                        ACT_INSERT: n_state = (is_full || is_empty) ? S_DONE : S_INS_CMP;
                        ACT_LOOKUP: n_state = is_empty ? S_DONE : S_LOOK_BACK;
                        ACT_TRIM:   n_state = (r_count > CW'(1)) ? S_TB_CMP : S_DONE;
                        ACT_FLUSH:  n_state = S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_INS_CMP:   n_state = S_DONE;
            S_LOOK_BACK: n_state = req_before ? S_DONE : S_SCAN_CMP;
            S_SCAN_CMP:  n_state = req_before ? S_SCAN_CMP : S_DONE;
            S_TB_CMP: begin
                if (!back_old) begin
                    n_state = S_TF_CMP;
                end else if (cnt_m1 > CW'(1)) begin
                    n_state = S_TB_CMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_TF_CMP: n_state = (front_new && cnt_m1 > CW'(1)) ? S_TF_CMP : S_DONE;
            S_DONE:   n_state = i_take ? S_IDLE : S_DONE;
            default:  n_state = S_IDLE;
        endcase
    end

    // memory accesses and register updates
    always_comb begin
        n_front   = r_front;
        n_count   = r_count;
        n_k       = r_k;
        n_req     = r_req;
        n_handle  = r_handle;
        n_status  = r_status;
        o_wr_en   = 1'b0;
        o_wr_addr = '0;
        o_wr_data = {cur.stamp, HANDLE_BITS'(cur.handle_in)};
        o_rd_en   = 1'b0;
        o_rd_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req    = i_req;
                    n_handle = '0;
                    n_status = ST_OK;
                    unique case (i_req.action)
                        ACT_INSERT: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else if (is_empty) begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = front_dec;
                                n_front   = front_dec;
                                n_count   = r_count + CW'(1);
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = r_front;
                            end
                        end
                        ACT_LOOKUP: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = back_slot;
                            end
                        end
                        ACT_TRIM: begin
                            if (r_count > CW'(1)) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = back_slot;
                            end
                        end
                        ACT_FLUSH: begin
                            n_front = '0;
                            n_count = '0;
                        end
                        default: begin
                            n_front = r_front;
                        end
                    endcase
                end
            end
            S_INS_CMP: begin
                // newer than the front goes in front, otherwise at the back
                o_wr_en = 1'b1;
                if (new_is_newer) begin
                    o_wr_addr = front_dec;
                    n_front   = front_dec;
                end else begin
                    o_wr_addr = slot_of(r_front, r_count);
                end
                n_count = r_count + CW'(1);
            end
            S_LOOK_BACK: begin
                n_handle = rd_handle;
                if (!req_before) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_front;
                    n_k       = CW'(1);
                end
            end
            S_SCAN_CMP: begin
                // the back entry always matches, so the scan ends
                if (!req_before) begin
                    n_handle = rd_handle;
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = slot_of(r_front, r_k);
                    n_k       = r_k + CW'(1);
                end
            end
            S_TB_CMP: begin
                if (back_old) begin
                    n_count = cnt_m1;
                    if (cnt_m1 > CW'(1)) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = slot_of(r_front, cnt_m2);
                    end
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_front;
                end
            end
            S_TF_CMP: begin
                if (front_new) begin
                    n_front = front_inc;
                    n_count = cnt_m1;
                    if (cnt_m1 > CW'(1)) begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = front_inc;
                    end
                end
            end
            S_DONE: begin
                n_k = r_k;
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_k     <= n_k;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_handle <= n_handle;
        r_status <= n_status;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    always_comb begin
        o_rsp            = '0;
        o_rsp.handle_out = r_handle;
        o_rsp.status     = r_status;
        o_rsp.occupancy  = OCC_W'(r_count);
    end

endmodule

@@ rtl/core/timestamped_frame_deque.sv @@
// Flush, a full insert and an insert or lookup on an empty queue go straight to the done
// state; other inserts first compare with the front entry, a lookup with the back entry
// and may then scan from the front, and a trim pops from the back, then from the front.
// One request is worked at a time; each scan or pop step is one read of the entry memory.
// A result waiting in the output register does not block acceptance of the next request.
// Reset (synchronous, active low) empties the queue; the entry memory is not cleared.
module timestamped_frame_deque #(
    parameter int DEPTH       = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  tfd_pkg::t_req  i_in_req,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output tfd_pkg::t_rsp  o_out_rsp,
    input  logic           i_out_stall
);

    import tfd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int MW = STAMP_W + HANDLE_BITS;

    logic          busy;
    logic          done;
    logic          take;
    t_rsp          rsp;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [MW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [MW-1:0] rd_data;

    logic          r_out_valid;
    t_rsp          r_out_rsp;

    tfd_ctrl #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_in_valid && !busy),
        .i_req     (i_in_req),
        .o_busy    (busy),
        .o_done    (done),
        .o_rsp     (rsp),
        .i_take    (take),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    tfd_ram #(
        .DEPTH (DEPTH),
        .WIDTH (MW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // move the finished result into the output register when it is free
    assign take = done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // hold the result while stalled
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_rsp <= rsp;
        end
    end

    assign o_in_stall  = busy;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

@@ bench/timestamped_frame_deque_chk.sv @@
module timestamped_frame_deque_chk #(
    parameter int DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  tfd_pkg::t_req i_in_req,
    input  logic          i_in_stall,
    input  logic          i_out_valid,
    input  tfd_pkg::t_rsp i_out_rsp,
    input  logic          i_out_stall,
    output int            o_fails,
    output int            o_pending
);

    import tfd_pkg::*;

    // Shadow copy of the deque: slot contents, front slot and entry count
    logic signed [STAMP_W-1:0] slot_stamp  [DEPTH];
    logic        [HANDLE_W-1:0] slot_handle [DEPTH];
    int front_slot = 0;
    int held       = 0;

    t_rsp expected_rsps[$];
    t_rsp want;

    task automatic report_mismatch(input string msg);
        $display("[chk] %0t: %s", $time, msg);
        o_fails++;
    endtask

    // Apply one request to the shadow deque and return the result it should give
    function automatic t_rsp predict_deque_result(input t_req r);
        logic signed [STAMP_W-1:0] stamp;
        logic signed [STAMP_W-1:0] lo;
        logic signed [STAMP_W-1:0] hi;
        t_rsp rsp;
        int back;
        int s;
        bit found;
        stamp = r.stamp;
        lo    = r.trim_low;
        hi    = r.trim_high;
        rsp.handle_out = '0;
        rsp.status     = ST_OK;
        case (r.action)
            ACT_INSERT: begin
                if (held >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else if (held == 0 || stamp > slot_stamp[front_slot]) begin
                    // newer than the front: push at the front
                    front_slot = (front_slot + DEPTH - 1) % DEPTH;
                    slot_stamp[front_slot]  = stamp;
                    slot_handle[front_slot] = r.handle_in;
                    held++;
                end else begin
                    // equal or older: push at the back
                    s = (front_slot + held) % DEPTH;
                    slot_stamp[s]  = stamp;
                    slot_handle[s] = r.handle_in;
                    held++;
                end
            end
            ACT_LOOKUP: begin
                if (held == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    back = (front_slot + held - 1) % DEPTH;
                    rsp.handle_out = slot_handle[back];
                    // scan from the front unless the time is older than the back
                    if (stamp >= slot_stamp[back]) begin
                        found = 1'b0;
                        for (int k = 0; k < held && !found; k++) begin
                            s = (front_slot + k) % DEPTH;
                            if (stamp >= slot_stamp[s]) begin
                                rsp.handle_out = slot_handle[s];
                                found = 1'b1;
                            end
                        end
                    end
                end
            end
            ACT_TRIM: begin
                // drop old entries at the back, then new ones at the front; keep one
                while (held > 1 && slot_stamp[(front_slot + held - 1) % DEPTH] < lo)
                    held--;
                while (held > 1 && slot_stamp[front_slot] > hi) begin
                    front_slot = (front_slot + 1) % DEPTH;
                    held--;
                end
            end
            default: begin
                front_slot = 0;
                held       = 0;
            end
        endcase
        rsp.occupancy = held[OCC_W-1:0];
        return rsp;
    endfunction

    // Check each delivered result against the oldest expectation, then log new requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            front_slot = 0;
            held       = 0;
            expected_rsps.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_rsps.size() == 0) begin
                    report_mismatch($sformatf("unexpected result handle %h status %0d occ %0d",
                        i_out_rsp.handle_out, i_out_rsp.status, i_out_rsp.occupancy));
                end else begin
                    want = expected_rsps[0];
                    expected_rsps.delete(0);
                    if (i_out_rsp.handle_out !== want.handle_out)
                        report_mismatch($sformatf("handle_out %h, want %h",
                            i_out_rsp.handle_out, want.handle_out));
                    if (i_out_rsp.status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                            i_out_rsp.status, want.status));
                    if (i_out_rsp.occupancy !== want.occupancy)
                        report_mismatch($sformatf("occupancy %0d, want %0d",
                            i_out_rsp.occupancy, want.occupancy));
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_rsps.push_back(predict_deque_result(i_in_req));
        end
        o_pending = expected_rsps.size();
    end

endmodule

@@ bench/timestamped_frame_deque_tb.sv @@
module timestamped_frame_deque_tb;
    import tfd_pkg::*;

    localparam int DEPTH = 16;

    logic i_clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_req in_req    = '0;
    logic in_stall;
    logic out_valid;
    t_rsp out_rsp;
    logic out_stall = 1'b0;

    int fails;
    int pending;
    int sender_gap_pct     = 25;
    int receiver_stall_pct = 73;
    logic signed [STAMP_W-1:0] frame_clock = '0;

    timestamped_frame_deque #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_req    (in_req),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_rsp   (out_rsp),
        .i_out_stall (out_stall)
    );

    timestamped_frame_deque_chk #(
        .DEPTH (DEPTH)
    ) chk (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_req    (in_req),
        .i_in_stall  (in_stall),
        .i_out_valid (out_valid),
        .i_out_rsp   (out_rsp),
        .i_out_stall (out_stall),
        .o_fails     (fails),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        out_stall = ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // Bound the run
    initial begin
        #2_000_000;
        $display("[timestamped_frame_deque] ERROR");
        $finish;
    end

    function automatic t_req make_req(input t_action act, input logic signed [63:0] stamp,
                                      input logic [HANDLE_W-1:0] handle,
                                      input logic signed [63:0] lo,
                                      input logic signed [63:0] hi);
        t_req r;
        r.action    = act;
        r.stamp     = stamp;
        r.handle_in = handle;
        r.trim_low  = lo;
        r.trim_high = hi;
        return r;
    endfunction

    // Mostly a rising frame clock with lookups and trims near it; some wild values
    function automatic t_req next_random_req();
        t_req r;
        int pick;
        int shape;
        r.stamp     = {$urandom, $urandom};
        r.handle_in = HANDLE_W'($urandom);
        r.trim_low  = {$urandom, $urandom};
        r.trim_high = {$urandom, $urandom};
        pick  = $urandom_range(0, 99);
        shape = $urandom_range(0, 99);
        if (pick < 45) begin
            r.action = ACT_INSERT;
            if (shape < 75) begin
                frame_clock = frame_clock + $urandom_range(1, 40);
                r.stamp = frame_clock;
            end else if (shape < 90) begin
                r.stamp = frame_clock - $urandom_range(0, 200);
            end
        end else if (pick < 75) begin
            r.action = ACT_LOOKUP;
            if (shape < 90)
                r.stamp = frame_clock - $urandom_range(0, 400);
        end else if (pick < 97) begin
            r.action = ACT_TRIM;
            if (shape < 90) begin
                r.trim_low  = frame_clock - $urandom_range(0, 600);
                r.trim_high = frame_clock - $urandom_range(0, 300);
            end
        end else begin
            r.action = ACT_FLUSH;
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic push_request(input t_req r);
        while ($urandom_range(0, 99) < sender_gap_pct) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_req   = r;
        in_valid = 1'b1;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic drain_outstanding();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        rst_n = 1'b1;

        // Directed: empty cases, extremes, equal time, keep-one trim, full
        push_request(make_req(ACT_LOOKUP, 64'sd0, 16'h0000, '0, '0));
        push_request(make_req(ACT_TRIM, 64'sd0, 16'h0000, '0, '0));
        push_request(make_req(ACT_INSERT, 64'sd0, 16'hffff, '0, '0));
        push_request(make_req(ACT_INSERT, 64'sd0, 16'h0001, '0, '0));
        push_request(make_req(ACT_INSERT, 64'h7fff_ffff_ffff_ffff, 16'h8000, '0, '0));
        push_request(make_req(ACT_INSERT, 64'h8000_0000_0000_0000, 16'h0000, '0, '0));
        push_request(make_req(ACT_LOOKUP, -64'sd1, 16'h0000, '0, '0));
        push_request(make_req(ACT_LOOKUP, 64'h7fff_ffff_ffff_ffff, 16'h0000, '0, '0));
        push_request(make_req(ACT_TRIM, 64'sd0, 16'h0000,
                              64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000));
        for (int i = 0; i < DEPTH - 1; i++)
            push_request(make_req(ACT_INSERT, 64'sd100 + 10 * i, HANDLE_W'(i + 1), '0, '0));
        push_request(make_req(ACT_INSERT, 64'sd500, 16'h5a5a, '0, '0));
        push_request(make_req(ACT_LOOKUP, 64'sd50, 16'h0000, '0, '0));
        push_request(make_req(ACT_FLUSH, 64'sd0, 16'h0000, '0, '0));

        // Random phases with different idling, waiting for a drain between them
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    sender_gap_pct     = 25;
                    receiver_stall_pct = 73;
                end
                1: begin
                    sender_gap_pct     = 73;
                    receiver_stall_pct = 25;
                end
                default: begin
                    sender_gap_pct     = 0;
                    receiver_stall_pct = 0;
                end
            endcase
            frame_clock = $signed({$urandom, $urandom}) >>> 2;
            repeat (142) push_request(next_random_req());
            drain_outstanding();
        end

        // Let any stray result show up before the verdict
        repeat (4 * (DEPTH + 3)) @(negedge i_clk);
        if (fails == 0 && pending == 0)
            $display("[timestamped_frame_deque] OK");
        else
            $display("[timestamped_frame_deque] ERROR");
        $finish;
    end

endmodule
